[rtl/core/xenc_pkg.sv]
// Shared types, constants and encoding helpers for the x86-64 ALU instruction encoder.
package xenc_pkg;

   // Buffer size and byte counter width
   localparam int unsigned BUFFER_BYTES = 65536;
   localparam int unsigned COUNT_W      = $clog2(BUFFER_BYTES + 1);

   // Decoded plan geometry
   localparam int unsigned SEG_BYTES   = 10;
   localparam int unsigned SEG_LEN_W   = $clog2(SEG_BYTES + 1);
   localparam int unsigned SEG_IDX_W   = $clog2(SEG_BYTES);
   localparam int unsigned NUM_SEGS    = 7;
   localparam int unsigned SEG_SEL_W   = $clog2(NUM_SEGS + 1);
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Opcode and prefix bytes
   localparam logic [7:0] OP_MOV_RM   = 8'h89;
   localparam logic [7:0] OP_ADD_RM   = 8'h01;
   localparam logic [7:0] OP_SUB_RM   = 8'h29;
   localparam logic [7:0] OP_AND_RM   = 8'h21;
   localparam logic [7:0] OP_OR_RM    = 8'h09;
   localparam logic [7:0] OP_XOR_RM   = 8'h31;
   localparam logic [7:0] OP_MOV_IMM  = 8'hB8;
   localparam logic [7:0] OP_RET      = 8'hC3;
   localparam logic [7:0] OP_PUSH_RBP = 8'h55;
   localparam logic [7:0] OP_POP_RBP  = 8'h5D;
   localparam logic [7:0] REX_BASE    = 8'h40;
   localparam logic [7:0] REX_W       = 8'h48;
   localparam logic [7:0] REX_B       = 8'h41;
   localparam logic [7:0] MODRM_REG   = 8'hC0;
   localparam logic [31:0] IMM32_MAX  = 32'hFFFF_FFFF;
   localparam logic [3:0] REG_RSP     = 4'd4;
   localparam logic [3:0] REG_RBP     = 4'd5;

   // Action codes
   typedef enum logic [3:0] {
      ACT_MOV      = 4'd0,
      ACT_MOVI     = 4'd1,
      ACT_ADD      = 4'd2,
      ACT_SUB      = 4'd3,
      ACT_AND      = 4'd4,
      ACT_OR       = 4'd5,
      ACT_XOR      = 4'd6,
      ACT_RET      = 4'd7,
      ACT_PROLOGUE = 4'd8,
      ACT_EPILOGUE = 4'd9,
      ACT_CLEAR    = 4'd10,
      ACT_OTHER    = 4'd11
   } action_type;

   // Segment slots, in emission order
   typedef enum logic [SEG_SEL_W-1:0] {
      SEG_PRE  = 3'd0,
      SEG_LD1  = 3'd1,
      SEG_LD2  = 3'd2,
      SEG_MV   = 3'd3,
      SEG_LD3  = 3'd4,
      SEG_ALU  = 3'd5,
      SEG_POST = 3'd6
   } seg_sel_type;

   // Input item
   typedef struct packed {
      logic [3:0]  action;
      logic [3:0]  dest_num;
      logic        dest_ok;
      logic [3:0]  src1_num;
      logic        src1_ok;
      logic        src1_is_const;
      logic [63:0] src1_value;
      logic [3:0]  src2_num;
      logic        src2_ok;
      logic        src2_is_const;
      logic [63:0] src2_value;
      logic [63:0] immediate;
   } req_type;

   // Result item
   typedef struct packed {
      logic [7:0]  code_byte;
      logic [15:0] byte_offset;
      logic        dropped;
      logic        last_byte;
   } rsp_type;

   // One byte string of the plan
   typedef struct packed {
      logic                            en;
      logic [SEG_LEN_W-1:0]            len;
      logic [SEG_BYTES-1:0][7:0]       data;
   } seg_type;

   // Decoded item, passed from front to back
   typedef struct packed {
      logic                     clear;
      seg_type [NUM_SEGS-1:0]   seg;
   } plan_type;

   // Single byte segment
   function automatic seg_type enc_byte(logic [7:0] b);
      seg_type s;
      s         = '0;
      s.en      = 1'b1;
      s.len     = SEG_LEN_W'(1);
      s.data[0] = b;
      return s;
   endfunction

   // REX.W op r/m64, r64 with register-direct ModRM
   function automatic seg_type enc_rr(logic [7:0] op, logic [3:0] rnum, logic [3:0] rm);
      seg_type s;
      s         = '0;
      s.en      = 1'b1;
      s.len     = SEG_LEN_W'(3);
      s.data[0] = REX_W | {5'b0, rnum[3], 1'b0, rm[3]};
      s.data[1] = op;
      s.data[2] = MODRM_REG | {2'b0, rnum[2:0], rm[2:0]};
      return s;
   endfunction

   // MOV r32, imm32 or REX.W MOV r64, imm64
   function automatic seg_type enc_movi(logic [3:0] rnum, logic [63:0] v);
      seg_type    s;
      logic [7:0] opc;
      s   = '0;
      opc = OP_MOV_IMM + {5'b0, rnum[2:0]};
      s.en = 1'b1;
      if (v[63:32] == 32'b0) begin
         if (rnum[3]) begin
            s.len     = SEG_LEN_W'(6);
            s.data[0] = REX_B;
            s.data[1] = opc;
            s.data[5:2] = v[31:0];
         end else begin
            s.len     = SEG_LEN_W'(5);
            s.data[0] = opc;
            s.data[4:1] = v[31:0];
         end
      end else begin
         s.len       = SEG_LEN_W'(10);
         s.data[0]   = REX_W | {7'b0, rnum[3]};
         s.data[1]   = opc;
         s.data[9:2] = v;
      end
      return s;
   endfunction

   // ALU opcode for the two-operand actions
   function automatic logic [7:0] alu_opcode(logic [3:0] act);
      logic [7:0] op;
      unique case (act)
         ACT_ADD: op = OP_ADD_RM;
         ACT_SUB: op = OP_SUB_RM;
         ACT_AND: op = OP_AND_RM;
         ACT_OR:  op = OP_OR_RM;
         ACT_XOR: op = OP_XOR_RM;
         default: op = OP_XOR_RM;
      endcase
      return op;
   endfunction

endpackage

[rtl/core/xenc_front.sv]
// Front end: classifies one instruction item into an ordered plan of byte strings.
module xenc_front (
   input  xenc_pkg::req_type  req,
   output xenc_pkg::plan_type plan
);
   import xenc_pkg::*;

   logic is_pro, is_epi, is_clr, is_mov, is_movi, is_alu, is_ret;
   logic loads_ok, all_ok;

   // Classify the action
   always_comb begin
      is_pro   = (req.action == ACT_PROLOGUE);
      is_epi   = (req.action == ACT_EPILOGUE);
      is_clr   = (req.action == ACT_CLEAR);
      is_mov   = (req.action == ACT_MOV);
      is_movi  = (req.action == ACT_MOVI);
      is_ret   = (req.action == ACT_RET);
      is_alu   = (req.action >= ACT_ADD) && (req.action <= ACT_XOR);
      loads_ok = !(is_pro || is_epi || is_clr);
      all_ok   = req.dest_ok && req.src1_ok && req.src2_ok;
   end

   // Build the segment list in emission order
   always_comb begin
      plan       = '0;
      plan.clear = is_clr;

      if (is_pro) begin
         plan.seg[SEG_PRE] = enc_byte(OP_PUSH_RBP);
      end else if (is_epi) begin
         plan.seg[SEG_PRE] = enc_byte(OP_POP_RBP);
      end

      if (loads_ok && req.src1_is_const && req.src1_ok) begin
         plan.seg[SEG_LD1] = enc_movi(req.src1_num, req.src1_value);
      end
      if (loads_ok && req.src2_is_const && req.src2_ok) begin
         plan.seg[SEG_LD2] = enc_movi(req.src2_num, req.src2_value);
      end

      if (is_pro) begin
         plan.seg[SEG_MV] = enc_rr(OP_MOV_RM, REG_RSP, REG_RBP);
      end else if ((is_mov && req.dest_ok && req.src1_ok) ||
                   (is_alu && all_ok && (req.dest_num != req.src1_num))) begin
         plan.seg[SEG_MV] = enc_rr(OP_MOV_RM, req.src1_num, req.dest_num);
      end

      if (is_movi && req.dest_ok) begin
         plan.seg[SEG_LD3] = enc_movi(req.dest_num, req.immediate);
      end

      if (is_alu && all_ok) begin
         plan.seg[SEG_ALU] = enc_rr(alu_opcode(req.action), req.src2_num, req.dest_num);
      end

      if (is_epi || is_ret) begin
         plan.seg[SEG_POST] = enc_byte(OP_RET);
      end
   end

endmodule

[rtl/core/xenc_queue.sv]
// Short plan queue between the front end and the byte emitter.
module xenc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   input  xenc_pkg::plan_type wr_plan,
   output logic               full,
   output logic               rd_valid,
   output xenc_pkg::plan_type rd_plan,
   input  logic               rd_pop
);
   import xenc_pkg::*;

   plan_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     push, pop;

   // Pointer and fill count update
   always_comb begin
      full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
      rd_valid = (count_ff != '0);
      rd_plan  = entry_ff[rd_ptr_ff];
      push     = wr_valid && !full;
      pop      = rd_pop && rd_valid;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_plan;
      end
   end

endmodule

[rtl/core/xenc_back.sv]
// Back end: walks a plan one byte per cycle unless stalled and counts buffer bytes.
module xenc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               plan_valid,
   input  xenc_pkg::plan_type plan,
   output logic               plan_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output xenc_pkg::rsp_type  rsp_data
);
   import xenc_pkg::*;

   logic [SEG_SEL_W-1:0] seg_sel_ff, seg_sel_in;
   logic [SEG_IDX_W-1:0] byte_idx_ff, byte_idx_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 advance, found, any_later, seg_last, emit, full;
   logic [SEG_SEL_W-1:0] cur;
   seg_type              cur_seg;

   // Find the first enabled segment at or after the current slot
   always_comb begin
      found = 1'b0;
      cur   = '0;
      for (int i = NUM_SEGS - 1; i >= 0; i--) begin
         if (plan.seg[i].en && (SEG_SEL_W'(i) >= seg_sel_ff)) begin
            found = 1'b1;
            cur   = SEG_SEL_W'(i);
         end
      end
      any_later = 1'b0;
      for (int i = 0; i < NUM_SEGS; i++) begin
         if (plan.seg[i].en && (SEG_SEL_W'(i) > cur)) begin
            any_later = 1'b1;
         end
      end
      cur_seg = plan.seg[cur];
   end

   // Emit one byte, advance position, drop the plan when done
   always_comb begin
      advance  = !rsp_valid_ff || !rsp_stall;
      full     = (count_ff >= COUNT_W'(BUFFER_BYTES));
      seg_last = (byte_idx_ff == SEG_IDX_W'(cur_seg.len - 1'b1));
      emit     = 1'b0;
      plan_pop = 1'b0;
      if (plan_valid && advance) begin
         if (plan.clear || !found) begin
            plan_pop = 1'b1;
         end else begin
            emit = 1'b1;
            if (seg_last && !any_later) begin
               plan_pop = 1'b1;
            end
         end
      end

      seg_sel_in  = seg_sel_ff;
      byte_idx_in = byte_idx_ff;
      if (plan_pop) begin
         seg_sel_in  = '0;
         byte_idx_in = '0;
      end else if (emit) begin
         if (seg_last) begin
            seg_sel_in  = cur + 1'b1;
            byte_idx_in = '0;
         end else begin
            byte_idx_in = byte_idx_ff + 1'b1;
         end
      end

      count_in = count_ff;
      if (plan_pop && plan.clear) begin
         count_in = '0;
      end else if (emit && !full) begin
         count_in = count_ff + 1'b1;
      end

      rsp_in             = rsp_ff;
      rsp_in.code_byte   = cur_seg.data[byte_idx_ff];
      rsp_in.byte_offset = full ? 16'b0 : count_ff[15:0];
      rsp_in.dropped     = full;
      rsp_in.last_byte   = seg_last && !any_later;

      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_sel_ff   <= '0;
         byte_idx_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seg_sel_ff   <= seg_sel_in;
         byte_idx_ff  <= byte_idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/core/x86_64_alu_instruction_encoder.sv]
// With the queue empty, an accepted item is first written to the plan queue, and its first
// byte then goes to the output register, where rsp_valid rises. The emitter sends one
// code byte per cycle unless stalled; an item has up to 30 bytes (3 to 6 typical) or none.
// A two-entry plan queue lets the input side keep accepting while bytes drain.
// Reset (synchronous, active high) empties the queue and output register and zeroes
// the buffer byte count.
module x86_64_alu_instruction_encoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  xenc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output xenc_pkg::rsp_type rsp_data
);
   import xenc_pkg::*;

   plan_type new_plan, head_plan;
   logic     q_full, head_valid, head_pop;

   // Classify incoming items
   xenc_front u_front (
      .req  (req_data),
      .plan (new_plan)
   );

   // Buffer decoded plans
   xenc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_valid),
      .wr_plan  (new_plan),
      .full     (q_full),
      .rd_valid (head_valid),
      .rd_plan  (head_plan),
      .rd_pop   (head_pop)
   );

   // Emit bytes
   xenc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .plan_valid (head_valid),
      .plan       (head_plan),
      .plan_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   assign req_stall = q_full;

endmodule

[dv/xenc_byte_checker.sv]
// Checker for the instruction encoder: predicts the code bytes of each item and compares them.
module xenc_byte_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  xenc_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  xenc_pkg::rsp_type rsp_data,
   output int                expected_left,
   output int                fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import xenc_pkg::*;

   // Predicted buffer fill and the code bytes still owed by the block
   logic [COUNT_W-1:0] stored_bytes;
   rsp_type            code_bytes_q[$];
   int                 mismatches;

   // Place one byte in the buffer, or mark it dropped once the buffer is full
   function automatic void put_code(logic [7:0] b);
      rsp_type r;
      r.code_byte = b;
      r.last_byte = 1'b0;
      if (stored_bytes >= BUFFER_BYTES) begin
         r.byte_offset = '0;
         r.dropped     = 1'b1;
      end else begin
         r.byte_offset = stored_bytes[15:0];
         r.dropped     = 1'b0;
         stored_bytes  = stored_bytes + 1'b1;
      end
      code_bytes_q.push_back(r);
   endfunction

   // REX.W, opcode, register-direct ModRM
   function automatic void put_reg_reg(logic [7:0] op, logic [3:0] rnum, logic [3:0] rm);
      put_code(REX_W | (8'(rnum[3]) << 2) | 8'(rm[3]));
      put_code(op);
      put_code(MODRM_REG | (8'(rnum[2:0]) << 3) | 8'(rm[2:0]));
   endfunction

   // MOV r32, imm32 when the value fits, else REX.W MOV r64, imm64
   function automatic void put_load(logic [3:0] rnum, logic [63:0] v);
      if (v <= 64'(IMM32_MAX)) begin
         if (rnum[3])
            put_code(REX_B);
         put_code(OP_MOV_IMM + 8'(rnum[2:0]));
         for (int i = 0; i < 4; i++)
            put_code(v[8*i +: 8]);
      end else begin
         put_code(REX_W | 8'(rnum[3]));
         put_code(OP_MOV_IMM + 8'(rnum[2:0]));
         for (int i = 0; i < 8; i++)
            put_code(v[8*i +: 8]);
      end
   endfunction

   // Expected code bytes of one accepted item
   function automatic void encode_item(req_type it);
      int         first;
      logic [7:0] alu_op;
      rsp_type    tail;
      first = code_bytes_q.size();
      case (it.action)
         ACT_SUB: alu_op = OP_SUB_RM;
         ACT_AND: alu_op = OP_AND_RM;
         ACT_OR:  alu_op = OP_OR_RM;
         ACT_XOR: alu_op = OP_XOR_RM;
         default: alu_op = OP_ADD_RM;
      endcase
      case (it.action)
         ACT_CLEAR: stored_bytes = '0;
         ACT_PROLOGUE: begin
            put_code(OP_PUSH_RBP);
            put_reg_reg(OP_MOV_RM, REG_RSP, REG_RBP);
         end
         ACT_EPILOGUE: begin
            put_code(OP_POP_RBP);
            put_code(OP_RET);
         end
         default: begin
            // constant sources are loaded first, src1 before src2
            if (it.src1_is_const && it.src1_ok)
               put_load(it.src1_num, it.src1_value);
            if (it.src2_is_const && it.src2_ok)
               put_load(it.src2_num, it.src2_value);
            case (it.action)
               ACT_MOV: begin
                  if (it.dest_ok && it.src1_ok)
                     put_reg_reg(OP_MOV_RM, it.src1_num, it.dest_num);
               end
               ACT_MOVI: begin
                  if (it.dest_ok)
                     put_load(it.dest_num, it.immediate);
               end
               ACT_ADD, ACT_SUB, ACT_AND, ACT_OR, ACT_XOR: begin
                  if (it.dest_ok && it.src1_ok && it.src2_ok) begin
                     if (it.dest_num != it.src1_num)
                        put_reg_reg(OP_MOV_RM, it.src1_num, it.dest_num);
                     put_reg_reg(alu_op, it.src2_num, it.dest_num);
                  end
               end
               ACT_RET: put_code(OP_RET);
               default: ;
            endcase
         end
      endcase
      // flag the final byte of the item
      if (code_bytes_q.size() > first) begin
         tail           = code_bytes_q.pop_back();
         tail.last_byte = 1'b1;
         code_bytes_q.push_back(tail);
      end
   endfunction

   // Predict on input, compare on output
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         stored_bytes = '0;
         code_bytes_q.delete();
      end else begin
         if (req_valid && !req_stall)
            encode_item(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (code_bytes_q.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected code byte, expected none, %s %02h %04h %b %b",
                        $time, "got byte/offset/dropped/last", rsp_data.code_byte,
                        rsp_data.byte_offset, rsp_data.dropped, rsp_data.last_byte);
            end else begin
               want = code_bytes_q.pop_front();
               if (rsp_data !== want) begin
                  mismatches++;
                  $display("%0t: code byte mismatch, expected %02h %04h %b %b",
                           $time, want.code_byte, want.byte_offset, want.dropped,
                           want.last_byte);
                  $display("%0t:   got %02h %04h %b %b",
                           $time, rsp_data.code_byte, rsp_data.byte_offset,
                           rsp_data.dropped, rsp_data.last_byte);
               end
            end
         end
      end
      expected_left <= code_bytes_q.size();
      fail_count    <= mismatches;
   end

endmodule

[dv/tb_x86_64_alu_instruction_encoder.sv]
// Testbench top for the instruction encoder: clock, reset, item stimulus, idling and verdict.
module tb_x86_64_alu_instruction_encoder;
   timeunit 1ns;
   timeprecision 1ps;
   import xenc_pkg::*;

   localparam logic [3:0] ACT_SPARE_FIRST = 4'd12;
   localparam logic [3:0] ACT_SPARE_LAST  = 4'd15;
   localparam int RANDOM_ITEMS   = 110;
   localparam int LONG_ITEMS     = 4;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int STALL_LIMIT    = 2000;
   localparam int END_CYCLES     = 20;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int expected_left;
   int fail_count;
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int hold_off_req  = 0;
   int hold_off_ack  = 0;
   int quiet_cycles  = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   x86_64_alu_instruction_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   xenc_byte_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .expected_left (expected_left),
      .fail_count    (fail_count)
   );

   // Receiver: random stall, or a long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req != hold_off_ack) begin
            hold_off_ack = hold_off_req;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Watchdog: end the run when no item moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("tb_x86_64_alu_instruction_encoder failed");
            $finish;
         end
      end
   end

   function automatic req_type make_instr(logic [3:0] act, logic [3:0] d, logic d_ok,
                                          logic [3:0] s1, logic s1_ok, logic s1_c,
                                          logic [63:0] s1_v, logic [3:0] s2, logic s2_ok,
                                          logic s2_c, logic [63:0] s2_v, logic [63:0] imm);
      req_type it;
      it.action        = act;
      it.dest_num      = d;
      it.dest_ok       = d_ok;
      it.src1_num      = s1;
      it.src1_ok       = s1_ok;
      it.src1_is_const = s1_c;
      it.src1_value    = s1_v;
      it.src2_num      = s2;
      it.src2_ok       = s2_ok;
      it.src2_is_const = s2_c;
      it.src2_value    = s2_v;
      it.immediate     = imm;
      return it;
   endfunction

   // Operand values biased toward the 32-bit boundary and the extremes
   function automatic logic [63:0] random_operand();
      case ($urandom_range(4))
         0: return {32'h0, $urandom};
         1: return {$urandom, $urandom};
         2: return '1;
         3: return 64'(IMM32_MAX) + 64'($urandom_range(1));
         default: return 64'($urandom_range(255));
      endcase
   endfunction

   // Mostly well-formed instructions, some with missing registers or odd actions
   function automatic req_type random_instr();
      req_type    it;
      int         pick;
      logic [3:0] act;
      pick = $urandom_range(99);
      if (pick < 55)      act = 4'($urandom_range(ACT_ADD, ACT_XOR));
      else if (pick < 67) act = ACT_MOV;
      else if (pick < 77) act = ACT_MOVI;
      else if (pick < 81) act = ACT_RET;
      else if (pick < 85) act = ACT_PROLOGUE;
      else if (pick < 89) act = ACT_EPILOGUE;
      else if (pick < 91) act = ACT_CLEAR;
      else if (pick < 96) act = ACT_OTHER;
      else                act = 4'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
      it = make_instr(act, 4'($urandom), $urandom_range(99) < 90,
                      4'($urandom), $urandom_range(99) < 90, $urandom_range(99) < 30,
                      random_operand(),
                      4'($urandom), $urandom_range(99) < 90, $urandom_range(99) < 30,
                      random_operand(), random_operand());
      // hit the in-place ALU form now and then
      if ($urandom_range(99) < 20)
         it.src1_num = it.dest_num;
      return it;
   endfunction

   // Offer one item, idling at random first, and hold it until accepted
   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Hold the sender until every predicted byte has come out
   task automatic drain_wait();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
   endtask

   initial begin
      send_idle_pct = 24;
      rsp_idle_pct  = 74;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every action, register extremes, immediate boundaries, missing registers
      send_item(make_instr(ACT_PROLOGUE, 4'd0, 1, 4'd1, 1, 1, 64'h1234, 4'd2, 1, 1,
                           64'h1_0000_5678, 64'h0));
      send_item(make_instr(ACT_MOV, 4'd0, 1, 4'd1, 1, 0, 64'h0, 4'd0, 0, 0, 64'h0, 64'h0));
      send_item(make_instr(ACT_MOV, 4'd15, 1, 4'd8, 1, 0, 64'h0, 4'd0, 0, 0, 64'h0, 64'h0));
      send_item(make_instr(ACT_MOVI, 4'd3, 1, 4'd0, 0, 0, 64'h0, 4'd0, 0, 0, 64'h0,
                           64'(IMM32_MAX)));
      send_item(make_instr(ACT_MOVI, 4'd12, 1, 4'd0, 0, 0, 64'h0, 4'd0, 0, 0, 64'h0, 64'h0));
      send_item(make_instr(ACT_MOVI, 4'd9, 1, 4'd0, 0, 0, 64'h0, 4'd0, 0, 0, 64'h0, '1));
      send_item(make_instr(ACT_MOVI, 4'd2, 1, 4'd0, 0, 0, 64'h0, 4'd0, 0, 0, 64'h0,
                           64'h1_0000_0000));
      for (int a = ACT_ADD; a <= ACT_XOR; a++)
         send_item(make_instr(4'(a), 4'(a + 7), 1, 4'(a), 1, 0, 64'h0, 4'(15 - a), 1, 0,
                              64'h0, 64'h0));
      send_item(make_instr(ACT_ADD, 4'd7, 1, 4'd7, 1, 0, 64'h0, 4'd8, 1, 0, 64'h0, 64'h0));
      send_item(make_instr(ACT_XOR, 4'd11, 1, 4'd10, 1, 1, 64'h8000_0001, 4'd14, 1, 1,
                           64'hDEAD_BEEF_0123_4567, 64'h0));
      send_item(make_instr(ACT_SUB, 4'd15, 1, 4'd15, 1, 1, '1, 4'd8, 1, 1, 64'h0, 64'h0));
      send_item(make_instr(ACT_MOV, 4'd1, 0, 4'd13, 1, 1, 64'h42, 4'd0, 0, 0, 64'h0, 64'h0));
      send_item(make_instr(ACT_ADD, 4'd1, 1, 4'd2, 1, 0, 64'h0, 4'd3, 0, 0, 64'h0, 64'h0));
      send_item(make_instr(ACT_MOVI, 4'd5, 0, 4'd0, 0, 0, 64'h0, 4'd0, 0, 0, 64'h0, 64'h55));
      send_item(make_instr(ACT_OTHER, 4'd0, 0, 4'd6, 0, 1, '1, 4'd7, 0, 1, '1, 64'h0));
      send_item(make_instr(ACT_RET, 4'd0, 1, 4'd0, 1, 0, 64'h0, 4'd12, 1, 1,
                           64'h0000_0000_FFFF_FFFE, 64'h0));
      send_item(make_instr(ACT_EPILOGUE, 4'd0, 1, 4'd3, 1, 1, 64'h7, 4'd0, 0, 0, 64'h0, 64'h0));
      send_item(make_instr(ACT_OTHER, 4'd0, 1, 4'd4, 1, 1, 64'h9, 4'd9, 1, 1,
                           64'hFFFF_FFFF_0000_0000, 64'h0));
      send_item(make_instr(ACT_SPARE_FIRST, 4'd0, 1, 4'd8, 1, 1, 64'h1, 4'd0, 0, 0, 64'h0,
                           64'h0));
      send_item(make_instr(ACT_SPARE_LAST, 4'd0, 1, 4'd0, 0, 0, 64'h0, 4'd15, 1, 1,
                           64'h1_2345_6789, 64'h0));
      send_item(make_instr(ACT_CLEAR, 4'd0, 1, 4'd1, 1, 1, 64'h3, 4'd2, 1, 1, 64'h4, 64'h0));
      send_item(make_instr(ACT_PROLOGUE, 4'd0, 0, 4'd0, 0, 0, 64'h0, 4'd0, 0, 0, 64'h0, 64'h0));

      // Random, slow receiver: long hold-off first so the input backs up
      hold_off_req++;
      repeat (RANDOM_ITEMS / 3) send_item(random_instr());
      drain_wait();

      // Random, slow sender, with a full pause halfway
      send_idle_pct = 74;
      rsp_idle_pct  = 24;
      repeat (RANDOM_ITEMS / 6) send_item(random_instr());
      drain_wait();
      repeat (RANDOM_ITEMS / 6) send_item(random_instr());

      // Random, no idling on either side
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      repeat (RANDOM_ITEMS / 3) send_item(random_instr());

      // Longest 30-byte items, then clear and restart
      send_item(make_instr(ACT_CLEAR, 4'd0, 0, 4'd0, 0, 0, 64'h0, 4'd0, 0, 0, 64'h0, 64'h0));
      repeat (LONG_ITEMS)
         send_item(make_instr(ACT_MOVI, 4'($urandom), 1,
                              4'($urandom), 1, 1, {32'h8000_0000 | $urandom, $urandom},
                              4'($urandom), 1, 1, {$urandom | 32'h1, $urandom},
                              {$urandom | 32'h4000_0000, $urandom}));
      repeat (4) send_item(random_instr());
      send_item(make_instr(ACT_CLEAR, 4'd0, 0, 4'd0, 0, 0, 64'h0, 4'd0, 0, 0, 64'h0, 64'h0));
      repeat (4) send_item(random_instr());

      drain_wait();
      repeat (END_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_left == 0)
         $display("tb_x86_64_alu_instruction_encoder passed");
      else
         $display("tb_x86_64_alu_instruction_encoder failed");
      $finish;
   end

endmodule
